@@ rtl/image_scale_flip_rotate_sampler_top_macros.svh @@
// assertion macros for the sampler checker
// used by isfrs_checker; needs clk and rst_n in the including scope
`ifndef IMAGE_SCALE_FLIP_ROTATE_SAMPLER_TOP_MACROS_SVH
`define IMAGE_SCALE_FLIP_ROTATE_SAMPLER_TOP_MACROS_SVH

// same-cycle implication
`define ISFRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ISFRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/isfrs_pkg.sv @@
// shared types and constants of the scale / flip / rotate sampler
// no dependencies
package isfrs_pkg;

  localparam int SRC_W_DEF   = 256;
  localparam int SRC_H_DEF   = 256;
  localparam int DST_W_DEF   = 256;
  localparam int DST_H_DEF   = 256;

  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_W       = 24;
  localparam int COORD_W     = 12;
  localparam int REGION_W    = 13;
  localparam int SCALE_W     = 16;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int FRAME_AW    = 16;
  localparam int FRAME_DEPTH = 65536;
  localparam int ACC_W       = 24;
  localparam int WGT_W       = 17;
  localparam int SIDE_W      = 9;
  localparam int BOX_W       = 18;
  localparam int POS_W       = 38;
  localparam int SIDE_NUM_W  = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE,
    CFG_INV_SCALE,
    CFG_TRANSFORM,
    CFG_FILTER,
    CFG_ORIGIN_X,
    CFG_ORIGIN_Y,
    CFG_REGION_W,
    CFG_REGION_H
  } cfg_idx_t;

  typedef enum logic {
    REQ_LOAD,
    REQ_RENDER
  } req_t;

  typedef enum logic [1:0] {
    MODE_NEAREST,
    MODE_BILINEAR,
    MODE_BOX
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_POS,
    ST_CHK,
    ST_SIDE,
    ST_FETCH,
    ST_DRAIN,
    ST_FIN,
    ST_DIV
  } state_t;

endpackage

@@ rtl/isfrs_ram.sv @@
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module isfrs_ram #(
  parameter int W     = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/isfrs_div.sv @@
// restoring divider, one quotient bit per cycle
// quotient must fit in QW bits; no dependencies
module isfrs_div #(
  parameter int NW = 30,
  parameter int DW = 30,
  parameter int QW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [QW-1:0] quo
);

  localparam int SW = DW + QW - 1;
  localparam int CW = (NW > SW) ? NW : SW;
  localparam int KW = $clog2(QW + 1);

  logic [NW-1:0] rem_r;
  logic [SW-1:0] dsh_r;
  logic [QW-1:0] q_r;
  logic [KW-1:0] cnt_r;
  logic          run_r;
  logic [CW-1:0] rem_ext;
  logic [CW-1:0] dsh_ext;
  logic [CW-1:0] diff;
  logic          ge;

  // trial subtract
  always_comb begin
    rem_ext = CW'(rem_r);
    dsh_ext = CW'(dsh_r);
    ge      = rem_ext >= dsh_ext;
    diff    = rem_ext - dsh_ext;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= KW'(QW);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == KW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= SW'(den) << (QW - 1);
      q_r   <= '0;
    end else if (run_r) begin
      if (ge) begin
        rem_r <= diff[NW-1:0];
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign busy = run_r;
  assign quo  = q_r;

endmodule

@@ rtl/image_scale_flip_rotate_sampler_top.sv @@
// top level of the scale / flip / rotate sampler
// uses isfrs_pkg, isfrs_ram and isfrs_div
//
//   channel   ports                                      handshake
//   request   start, busy, in_req_type .. in_src_pixel   start & !busy
//   result    out_valid, out_dest_x .. out_inside_res    out_valid, one cycle
//   config    cfg_we, cfg_idx, cfg_data                  cfg_we
//
// load: never busy; the pixel is written into the frame ram at acceptance
//   if it lies inside the frame. render: setup (mul, pos, chk), reads, drain
//   and fin; nearest does one read, bilinear four; box adds box-side division
//   before its bw*bh reads and channel division after; one read port serves all
// outside steps answer from chk; synchronous reset clears control and config
// results are strobed for one cycle and cannot be stalled
module image_scale_flip_rotate_sampler_top #(
  parameter int SRC_W = isfrs_pkg::SRC_W_DEF,
  parameter int SRC_H = isfrs_pkg::SRC_H_DEF,
  parameter int DST_W = isfrs_pkg::DST_W_DEF,
  parameter int DST_H = isfrs_pkg::DST_H_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_req_type,
  input  logic [isfrs_pkg::COORD_W-1:0]       in_coord_x,
  input  logic [isfrs_pkg::COORD_W-1:0]       in_coord_y,
  input  logic [isfrs_pkg::PIX_W-1:0]         in_src_pixel,
  output logic                                out_valid,
  output logic [isfrs_pkg::COORD_W-1:0]       out_dest_x,
  output logic [isfrs_pkg::COORD_W-1:0]       out_dest_y,
  output logic [isfrs_pkg::PIX_W-1:0]         out_pixel,
  output logic                                out_inside_res,
  input  logic                                cfg_we,
  input  logic [isfrs_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [isfrs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW  = isfrs_pkg::CHAN_W;
  localparam int XW  = isfrs_pkg::POS_W - 8 + 1;
  localparam logic [XW-1:0] XMAX = XW'(SRC_W - 1);
  localparam logic [XW-1:0] YMAX = XW'(SRC_H - 1);

  // configuration registers
  logic [isfrs_pkg::SCALE_W-1:0]  scale_r, inv_r;
  logic [2:0]                     tm_r;
  logic [1:0]                     fm_r;
  logic [isfrs_pkg::COORD_W-1:0]  ox_r, oy_r;
  logic [isfrs_pkg::REGION_W-1:0] rw_r, rh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 16'd256;
      inv_r   <= 16'd256;
      tm_r    <= '0;
      fm_r    <= '0;
      ox_r    <= '0;
      oy_r    <= '0;
      rw_r    <= '0;
      rh_r    <= '0;
    end else if (cfg_we) begin
      case (isfrs_pkg::cfg_idx_t'(cfg_idx))
        isfrs_pkg::CFG_SCALE:     scale_r <= cfg_data;
        isfrs_pkg::CFG_INV_SCALE: inv_r   <= cfg_data;
        isfrs_pkg::CFG_TRANSFORM: tm_r    <= cfg_data[2:0];
        isfrs_pkg::CFG_FILTER:    fm_r    <= cfg_data[1:0];
        isfrs_pkg::CFG_ORIGIN_X:  ox_r    <= cfg_data[11:0];
        isfrs_pkg::CFG_ORIGIN_Y:  oy_r    <= cfg_data[11:0];
        isfrs_pkg::CFG_REGION_W:  rw_r    <= cfg_data[12:0];
        isfrs_pkg::CFG_REGION_H:  rh_r    <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // zero scale registers act as one
  logic [15:0] s_eff, inc_eff;
  assign s_eff   = (scale_r == '0) ? 16'd1 : scale_r;
  assign inc_eff = (inv_r == '0) ? 16'd1 : inv_r;

  // state machine signals
  isfrs_pkg::state_t state_r, state_nxt;
  logic side_busy, chan_busy, step_in, is_box, empty_box, last_rd;
  logic side_start, chan_start, fetch_en, acc_clr, out_fire, mem_we;

  // request registers and setup pipeline
  logic [11:0] dx_r, dy_r;
  logic [28:0] rw_s_r, rh_s_r;
  logic [27:0] ox_s_r, oy_s_r;
  logic [isfrs_pkg::POS_W-1:0] px_r, py_r;
  logic [12:0] del_x_r, del_y_r;
  isfrs_pkg::mode_t mode_r, mode_c;
  logic [2:0]  tm_eff_r;
  logic [11:0] dest_x_r, dest_y_r;

  // fetch loop
  logic [isfrs_pkg::SIDE_W-1:0] cnt_x_r, cnt_y_r, lim_x, lim_y;
  logic [isfrs_pkg::SIDE_W-1:0] bw_q, bh_q;
  logic [isfrs_pkg::WGT_W-1:0]  wgt, wgt_d_r;
  logic                         rd_v_r;
  logic [isfrs_pkg::FRAME_AW-1:0] raddr, waddr;
  logic [isfrs_pkg::PIX_W-1:0]    rd_data;
  logic [isfrs_pkg::ACC_W-1:0]    acc_r [isfrs_pkg::NUM_CHAN];
  logic [CW-1:0]                  quo [isfrs_pkg::NUM_CHAN];
  logic [isfrs_pkg::BOX_W-1:0]    box_area;
  logic [2:0]                     chan_bsy;

  assign is_box    = (mode_r == isfrs_pkg::MODE_BOX);
  assign step_in   = ({1'b0, dx_r} < del_x_r) && ({1'b0, dy_r} < del_y_r);
  assign empty_box = (bw_q == '0) || (bh_q == '0);
  assign last_rd   = (cnt_x_r == lim_x - 1'b1) && (cnt_y_r == lim_y - 1'b1);
  assign chan_busy = |chan_bsy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isfrs_pkg::ST_IDLE:
        if (start && in_req_type == isfrs_pkg::REQ_RENDER) state_nxt = isfrs_pkg::ST_MUL;
      isfrs_pkg::ST_MUL:   state_nxt = isfrs_pkg::ST_POS;
      isfrs_pkg::ST_POS:   state_nxt = isfrs_pkg::ST_CHK;
      isfrs_pkg::ST_CHK:
        if (!step_in)    state_nxt = isfrs_pkg::ST_IDLE;
        else if (is_box) state_nxt = isfrs_pkg::ST_SIDE;
        else             state_nxt = isfrs_pkg::ST_FETCH;
      isfrs_pkg::ST_SIDE:
        if (!side_busy) state_nxt = empty_box ? isfrs_pkg::ST_IDLE : isfrs_pkg::ST_FETCH;
      isfrs_pkg::ST_FETCH:
        if (last_rd) state_nxt = isfrs_pkg::ST_DRAIN;
      isfrs_pkg::ST_DRAIN: state_nxt = isfrs_pkg::ST_FIN;
      isfrs_pkg::ST_FIN:   state_nxt = is_box ? isfrs_pkg::ST_DIV : isfrs_pkg::ST_IDLE;
      isfrs_pkg::ST_DIV:
        if (!chan_busy) state_nxt = isfrs_pkg::ST_IDLE;
      default: state_nxt = isfrs_pkg::ST_IDLE;
    endcase
  end

  // state machine outputs
  always_comb begin
    side_start = (state_r == isfrs_pkg::ST_CHK) && step_in && is_box;
    chan_start = (state_r == isfrs_pkg::ST_FIN) && is_box;
    fetch_en   = (state_r == isfrs_pkg::ST_FETCH);
    acc_clr    = (state_r == isfrs_pkg::ST_CHK);
    mem_we     = (state_r == isfrs_pkg::ST_IDLE) && start &&
                 (in_req_type == isfrs_pkg::REQ_LOAD) &&
                 (32'(in_coord_x) < 32'(SRC_W)) && (32'(in_coord_y) < 32'(SRC_H));
    out_fire   = ((state_r == isfrs_pkg::ST_CHK) && !step_in) ||
                 ((state_r == isfrs_pkg::ST_SIDE) && !side_busy && empty_box) ||
                 ((state_r == isfrs_pkg::ST_FIN) && !is_box) ||
                 ((state_r == isfrs_pkg::ST_DIV) && !chan_busy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isfrs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != isfrs_pkg::ST_IDLE);

  // filter mode selection
  always_comb begin
    if ((s_eff >= 16'd128 && s_eff < 16'd256) || (s_eff > 16'd256 && fm_r[0])) begin
      mode_c = isfrs_pkg::MODE_BILINEAR;
    end else if (fm_r[1] && s_eff < 16'd128) begin
      mode_c = isfrs_pkg::MODE_BOX;
    end else begin
      mode_c = isfrs_pkg::MODE_NEAREST;
    end
  end

  // setup arithmetic
  logic [28:0] ox_ceil_sum, oy_ceil_sum;
  logic [21:0] cx_sum, cy_sum;
  logic [20:0] dlx, dly;
  logic [12:0] lim_dx, lim_dy, del_x_c, del_y_c;
  logic [12:0] fx_d, fy_d;

  always_comb begin
    ox_ceil_sum = 29'(ox_s_r) + 29'd255;
    oy_ceil_sum = 29'(oy_s_r) + 29'd255;
    cx_sum      = 22'(ox_ceil_sum[28:8]) + 22'(dx_r);
    cy_sum      = 22'(oy_ceil_sum[28:8]) + 22'(dy_r);
    dlx         = rw_s_r[28:8];
    dly         = rh_s_r[28:8];
    lim_dx      = tm_r[2] ? 13'(DST_H) : 13'(DST_W);
    lim_dy      = tm_r[2] ? 13'(DST_W) : 13'(DST_H);
    del_x_c     = (dlx > 21'(lim_dx)) ? lim_dx : dlx[12:0];
    del_y_c     = (dly > 21'(lim_dy)) ? lim_dy : dly[12:0];
    if (mode_c == isfrs_pkg::MODE_BOX) begin
      if (del_x_c == '0) del_x_c = 13'd1;
      if (del_y_c == '0) del_y_c = 13'd1;
    end
    fx_d = tm_eff_r[0] ? (del_x_r - 13'd1 - 13'(dx_r)) : 13'(dx_r);
    fy_d = tm_eff_r[1] ? (del_y_r - 13'd1 - 13'(dy_r)) : 13'(dy_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == isfrs_pkg::ST_IDLE && start) begin
      dx_r <= in_coord_x;
      dy_r <= in_coord_y;
    end
    if (state_r == isfrs_pkg::ST_MUL) begin
      rw_s_r <= 29'(rw_r) * 29'(s_eff);
      rh_s_r <= 29'(rh_r) * 29'(s_eff);
      ox_s_r <= 28'(ox_r) * 28'(s_eff);
      oy_s_r <= 28'(oy_r) * 28'(s_eff);
    end
    if (state_r == isfrs_pkg::ST_POS) begin
      px_r     <= isfrs_pkg::POS_W'(cx_sum) * isfrs_pkg::POS_W'(inc_eff);
      py_r     <= isfrs_pkg::POS_W'(cy_sum) * isfrs_pkg::POS_W'(inc_eff);
      del_x_r  <= del_x_c;
      del_y_r  <= del_y_c;
      mode_r   <= mode_c;
      tm_eff_r <= tm_r ^ {1'b0, tm_r[2], 1'b0};
    end
    if (state_r == isfrs_pkg::ST_CHK) begin
      dest_x_r <= tm_eff_r[2] ? fy_d[11:0] : fx_d[11:0];
      dest_y_r <= tm_eff_r[2] ? fx_d[11:0] : fy_d[11:0];
    end
  end

  // box sides: floor((w*512 + d) / (2d)), d = w*s + 128
  logic [isfrs_pkg::SIDE_NUM_W-1:0] dw_c, dh_c, nw_c, nh_c;
  always_comb begin
    dw_c = 30'(rw_s_r) + 30'd128;
    dh_c = 30'(rh_s_r) + 30'd128;
    nw_c = {8'd0, rw_r, 9'd0} + dw_c;
    nh_c = {8'd0, rh_r, 9'd0} + dh_c;
  end

  logic bsy_w, bsy_h;
  isfrs_div #(.NW(isfrs_pkg::SIDE_NUM_W), .DW(isfrs_pkg::SIDE_NUM_W),
              .QW(isfrs_pkg::SIDE_W)) u_div_bw (
    .clk(clk), .rst_n(rst_n), .start(side_start),
    .num(nw_c), .den({dw_c[28:0], 1'b0}), .busy(bsy_w), .quo(bw_q)
  );
  isfrs_div #(.NW(isfrs_pkg::SIDE_NUM_W), .DW(isfrs_pkg::SIDE_NUM_W),
              .QW(isfrs_pkg::SIDE_W)) u_div_bh (
    .clk(clk), .rst_n(rst_n), .start(side_start),
    .num(nh_c), .den({dh_c[28:0], 1'b0}), .busy(bsy_h), .quo(bh_q)
  );
  assign side_busy = bsy_w | bsy_h;

  // read pattern per mode
  always_comb begin
    unique case (mode_r)
      isfrs_pkg::MODE_BOX: begin
        lim_x = bw_q;
        lim_y = bh_q;
      end
      isfrs_pkg::MODE_BILINEAR: begin
        lim_x = 9'd2;
        lim_y = 9'd2;
      end
      default: begin
        lim_x = 9'd1;
        lim_y = 9'd1;
      end
    endcase
  end

  // read address with edge clamp, and sample weight
  logic [XW-1:0] xs, ys;
  logic [11:0]   xc, yc;
  logic [8:0]    wa, wb;
  logic [17:0]   wprod;
  always_comb begin
    xs    = XW'(px_r[isfrs_pkg::POS_W-1:8]) + XW'(cnt_x_r);
    ys    = XW'(py_r[isfrs_pkg::POS_W-1:8]) + XW'(cnt_y_r);
    xc    = (xs > XMAX) ? XMAX[11:0] : xs[11:0];
    yc    = (ys > YMAX) ? YMAX[11:0] : ys[11:0];
    raddr = 16'((32'(yc) * 32'(SRC_W)) + 32'(xc));
    waddr = 16'((32'(in_coord_y) * 32'(SRC_W)) + 32'(in_coord_x));
    wa    = (cnt_x_r == '0) ? (9'd256 - 9'(px_r[7:0])) : 9'(px_r[7:0]);
    wb    = (cnt_y_r == '0) ? (9'd256 - 9'(py_r[7:0])) : 9'(py_r[7:0]);
    wprod = 18'(wa) * 18'(wb);
    unique case (mode_r)
      isfrs_pkg::MODE_BILINEAR: wgt = wprod[16:0];
      isfrs_pkg::MODE_BOX:      wgt = 17'd1;
      default:                  wgt = 17'h10000;
    endcase
  end

  // fetch counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r <= 1'b0;
    end else begin
      rd_v_r <= fetch_en;
    end
    if (acc_clr) begin
      cnt_x_r <= '0;
      cnt_y_r <= '0;
    end else if (fetch_en) begin
      if (cnt_x_r == lim_x - 1'b1) begin
        cnt_x_r <= '0;
        cnt_y_r <= cnt_y_r + 1'b1;
      end else begin
        cnt_x_r <= cnt_x_r + 1'b1;
      end
    end
    wgt_d_r <= wgt;
  end

  isfrs_ram #(.W(isfrs_pkg::PIX_W), .DEPTH(isfrs_pkg::FRAME_DEPTH)) u_frame (
    .clk(clk), .we(mem_we), .waddr(waddr), .wdata(in_src_pixel),
    .raddr(raddr), .rdata(rd_data)
  );

  // per-channel weighted accumulate and box average
  assign box_area = 18'(bw_q) * 18'(bh_q);

  for (genvar c = 0; c < isfrs_pkg::NUM_CHAN; c++) begin : g_chan
    logic [24:0] prod;
    assign prod = 25'(wgt_d_r) * 25'(rd_data[c*CW +: CW]);

    always_ff @(posedge clk) begin
      if (acc_clr) begin
        acc_r[c] <= '0;
      end else if (rd_v_r) begin
        acc_r[c] <= acc_r[c] + prod[isfrs_pkg::ACC_W-1:0];
      end
    end

    isfrs_div #(.NW(isfrs_pkg::ACC_W), .DW(isfrs_pkg::BOX_W), .QW(CW)) u_div_ch (
      .clk(clk), .rst_n(rst_n), .start(chan_start),
      .num(acc_r[c]), .den(box_area), .busy(chan_bsy[c]), .quo(quo[c])
    );
  end

  // result register
  logic                 out_valid_r, inside_out_r;
  logic [11:0]          out_x_r, out_y_r;
  logic [isfrs_pkg::PIX_W-1:0] out_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_fire;
    end
    if (out_fire) begin
      inside_out_r <= (state_r != isfrs_pkg::ST_CHK);
      out_x_r      <= (state_r == isfrs_pkg::ST_CHK) ? '0 : dest_x_r;
      out_y_r      <= (state_r == isfrs_pkg::ST_CHK) ? '0 : dest_y_r;
      unique case (state_r)
        isfrs_pkg::ST_FIN:
          out_pix_r <= {acc_r[2][23:16], acc_r[1][23:16], acc_r[0][23:16]};
        isfrs_pkg::ST_DIV:
          out_pix_r <= {quo[2], quo[1], quo[0]};
        default:
          out_pix_r <= '0;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_x     = out_x_r;
  assign out_dest_y     = out_y_r;
  assign out_pixel      = out_pix_r;
  assign out_inside_res = inside_out_r;

endmodule

@@ rtl/isfrs_checker.sv @@
// port-level checker for the sampler, bound to the top level
// uses image_scale_flip_rotate_sampler_top_macros.svh and isfrs_pkg
`include "image_scale_flip_rotate_sampler_top_macros.svh"

module isfrs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              in_req_type,
  input logic                              out_valid,
  input logic [isfrs_pkg::COORD_W-1:0]     out_dest_x,
  input logic [isfrs_pkg::COORD_W-1:0]     out_dest_y,
  input logic [isfrs_pkg::PIX_W-1:0]       out_pixel,
  input logic                              out_inside_res
);

  // a result is only shown once the block is free again
  `ISFRS_ASSERT_NOW(a_out_idle, out_valid, !busy, "result while busy")

  // an accepted render request occupies the block
  `ISFRS_ASSERT_NEXT(a_render_busy, start && !busy && in_req_type == isfrs_pkg::REQ_RENDER,
    busy, "render request did not start")

  // a load request gives no result
  `ISFRS_ASSERT_NEXT(a_load_quiet, start && !busy && in_req_type == isfrs_pkg::REQ_LOAD,
    !out_valid && !busy, "load request produced a result")

  // outside steps report all-zero fields
  `ISFRS_ASSERT_NOW(a_outside_zero, out_valid && !out_inside_res,
    out_dest_x == '0 && out_dest_y == '0 && out_pixel == '0, "outside result not zero")

endmodule

bind image_scale_flip_rotate_sampler_top isfrs_checker u_isfrs_checker (.*);

@@ verif/tb_image_scale_flip_rotate_sampler_top.sv @@
// self-checking testbench of the scale / flip / rotate sampler
// depends on isfrs_pkg and image_scale_flip_rotate_sampler_top
module tb_image_scale_flip_rotate_sampler_top;
  import isfrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int WIN = 12;

  typedef struct {
    logic         hold_for_drain;
    req_t         kind;
    logic [11:0]  cx;
    logic [11:0]  cy;
    logic [23:0]  pix;
  } request_t;

  typedef struct {
    logic [11:0] dx;
    logic [11:0] dy;
    logic [23:0] pix;
    logic        in_range;
  } sample_t;

  logic clk, rst_n, start, busy;
  logic in_req_type;
  logic [COORD_W-1:0] in_coord_x, in_coord_y;
  logic [PIX_W-1:0] in_src_pixel;
  logic out_valid, out_inside_res;
  logic [COORD_W-1:0] out_dest_x, out_dest_y;
  logic [PIX_W-1:0] out_pixel;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  request_t pending_requests[$];
  sample_t  expected_samples[$];
  int       sender_gap_pct;
  int       error_count;
  int       cycle_count;

  // shadow of the frame memory and of the registers
  logic [23:0] frame_shadow [0:65535];
  logic [15:0] m_scale, m_inv;
  logic [2:0]  m_transform;
  logic [1:0]  m_filter;
  logic [11:0] m_origin_x, m_origin_y;
  logic [12:0] m_region_w, m_region_h;

  image_scale_flip_rotate_sampler_top dut (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic [23:0] read_frame(longint unsigned x, longint unsigned y);
    if (x > 255) x = 255;
    if (y > 255) y = 255;
    return frame_shadow[(y * 256 + x) & 16'hFFFF];
  endfunction

  function automatic longint unsigned box_side(longint unsigned w, longint unsigned s);
    longint unsigned d;
    d = w * s + 128;
    return (w * 512 + d) / (2 * d);
  endfunction

  // expected result of one render request
  function automatic sample_t resample_step(logic [11:0] step_x, logic [11:0] step_y);
    sample_t r;
    longint unsigned s, inc, del_x, del_y, px, py, ix, iy, fx, fy, v, bw, bh, area, x, y, t;
    longint unsigned sum [3];
    logic [23:0] p0, p1, p2, p3, p;
    logic [2:0] tm;
    mode_t mode;
    r = '{default: '0};
    tm = m_transform;
    s = (m_scale != 0) ? m_scale : 1;
    inc = (m_inv != 0) ? m_inv : 1;
    del_x = (m_region_w * s) >> 8;
    del_y = (m_region_h * s) >> 8;
    if (tm[2]) begin
      if (del_x > 256) del_x = 256;
      if (del_y > 256) del_y = 256;
      tm[1] = ~tm[1];
    end else begin
      if (del_x > 256) del_x = 256;
      if (del_y > 256) del_y = 256;
    end
    if ((s >= 128 && s < 256) || (s > 256 && m_filter[0])) mode = MODE_BILINEAR;
    else if (m_filter[1] && s < 128) mode = MODE_BOX;
    else mode = MODE_NEAREST;
    if (mode == MODE_BOX) begin
      if (del_x == 0) del_x = 1;
      if (del_y == 0) del_y = 1;
    end
    if (step_x >= del_x || step_y >= del_y) return r;
    px = (((m_origin_x * s) + 255) >> 8) * inc + step_x * inc;
    py = (((m_origin_y * s) + 255) >> 8) * inc + step_y * inc;
    if (mode == MODE_BILINEAR) begin
      ix = px >> 8; iy = py >> 8; fx = px & 255; fy = py & 255;
      p0 = read_frame(ix, iy);
      p1 = read_frame(ix + 1, iy);
      p2 = read_frame(ix + 1, iy + 1);
      p3 = read_frame(ix, iy + 1);
      for (int c = 0; c < 3; c++) begin
        v = (256 - fx) * (256 - fy) * p0[8*c +: 8] + fx * (256 - fy) * p1[8*c +: 8]
          + fx * fy * p2[8*c +: 8] + (256 - fx) * fy * p3[8*c +: 8];
        r.pix[8*c +: 8] = v >> 16;
      end
    end else if (mode == MODE_BOX) begin
      bw = box_side(m_region_w, s);
      bh = box_side(m_region_h, s);
      area = bw * bh;
      sum = '{0, 0, 0};
      if (area != 0) begin
        for (longint unsigned by = 0; by < bh; by++)
          for (longint unsigned bx = 0; bx < bw; bx++) begin
            p = read_frame((px >> 8) + bx, (py >> 8) + by);
            for (int c = 0; c < 3; c++) sum[c] += p[8*c +: 8];
          end
        for (int c = 0; c < 3; c++) r.pix[8*c +: 8] = sum[c] / area;
      end
    end else begin
      r.pix = read_frame(px >> 8, py >> 8);
    end
    x = tm[0] ? (del_x - 1 - step_x) : step_x;
    y = tm[1] ? (del_y - 1 - step_y) : step_y;
    if (tm[2]) begin t = x; x = y; y = t; end
    r.dx = x[11:0];
    r.dy = y[11:0];
    r.in_range = 1'b1;
    return r;
  endfunction

  // driver: issues queued requests, with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_requests.size() != 0 && pending_requests[0].hold_for_drain) begin
        if (!start && !busy && !out_valid && expected_samples.size() == 0)
          void'(pending_requests.pop_front());
        start <= 1'b0;
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(99, 0) >= sender_gap_pct) begin
        request_t rq;
        rq = pending_requests.pop_front();
        start <= 1'b1;
        in_req_type <= rq.kind;
        in_coord_x <= rq.cx;
        in_coord_y <= rq.cy;
        in_src_pixel <= rq.pix;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: tracks registers and loads, predicts and checks results
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_idx))
          CFG_SCALE:     m_scale <= cfg_data;
          CFG_INV_SCALE: m_inv <= cfg_data;
          CFG_TRANSFORM: m_transform <= cfg_data[2:0];
          CFG_FILTER:    m_filter <= cfg_data[1:0];
          CFG_ORIGIN_X:  m_origin_x <= cfg_data[11:0];
          CFG_ORIGIN_Y:  m_origin_y <= cfg_data[11:0];
          CFG_REGION_W:  m_region_w <= cfg_data[12:0];
          CFG_REGION_H:  m_region_h <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected result dest_x=%0d dest_y=%0d", out_dest_x, out_dest_y);
          error_count++;
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (out_dest_x !== e.dx) begin
            $error("dest_x expected %0d actual %0d", e.dx, out_dest_x); error_count++;
          end
          if (out_dest_y !== e.dy) begin
            $error("dest_y expected %0d actual %0d", e.dy, out_dest_y); error_count++;
          end
          if (out_pixel !== e.pix) begin
            $error("out_pixel expected %06h actual %06h", e.pix, out_pixel); error_count++;
          end
          if (out_inside_res !== e.in_range) begin
            $error("inside_res expected %0d actual %0d", e.in_range, out_inside_res);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        if (req_t'(in_req_type) == REQ_LOAD) begin
          if (in_coord_x < 256 && in_coord_y < 256)
            frame_shadow[{in_coord_y[7:0], in_coord_x[7:0]}] = in_src_pixel;
        end else begin
          expected_samples.push_back(resample_step(in_coord_x, in_coord_y));
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int s, int inv, int tm, int fm, int ox, int oy, int w, int h);
    write_reg(CFG_SCALE, s);
    write_reg(CFG_INV_SCALE, inv);
    write_reg(CFG_TRANSFORM, tm);
    write_reg(CFG_FILTER, fm);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_REGION_W, w);
    write_reg(CFG_REGION_H, h);
  endtask

  task automatic push_request(req_t kind, int x, int y, int pix);
    pending_requests.push_back('{1'b0, kind, x[11:0], y[11:0], pix[23:0]});
  endtask

  // wait until all requests are out and every result is back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || busy || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // mostly steps near the output origin, some anywhere; a few loads mixed in
  task automatic random_requests(int count);
    for (int i = 0; i < count; i++) begin
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 12)
        push_request(REQ_LOAD, $urandom_range(4095, 0) & ($urandom_range(1, 0) ? 4095 : 255),
                     $urandom_range(4095, 0) & ($urandom_range(1, 0) ? 4095 : 255),
                     $urandom_range(24'hFFFFFF, 0));
      else if (pick < 25)
        push_request(REQ_RENDER, $urandom_range(4095, 0), $urandom_range(4095, 0), 0);
      else
        push_request(REQ_RENDER, $urandom_range(20, 0), $urandom_range(20, 0),
                     $urandom_range(24'hFFFFFF, 0));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req_type = REQ_LOAD;
    in_coord_x = '0;
    in_coord_y = '0;
    in_src_pixel = '0;
    cfg_we = 1'b0;
    cfg_idx = CFG_SCALE;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    sender_gap_pct = 0;
    m_scale = 256; m_inv = 256; m_transform = 0; m_filter = 0;
    m_origin_x = 0; m_origin_y = 0; m_region_w = 0; m_region_h = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // fill the top-left and bottom-right corners of the frame; every
    // setting below keeps its reads inside these two windows
    for (int y = 0; y < WIN; y++)
      for (int x = 0; x < WIN; x++) begin
        push_request(REQ_LOAD, x, y, $urandom_range(24'hFFFFFF, 0));
        push_request(REQ_LOAD, 255 - x, 255 - y, $urandom_range(24'hFFFFFF, 0));
      end
    wait_idle();

    // directed: field extremes, ignored loads, edge clamp, outside steps
    configure(256, 256, 0, 0, 0, 0, 256, 256);
    push_request(REQ_LOAD, 4095, 0, 24'hFFFFFF);
    push_request(REQ_LOAD, 0, 4095, 24'h000000);
    push_request(REQ_LOAD, 256, 256, 24'hABCDEF);
    push_request(REQ_LOAD, 255, 255, 24'hFFFFFF);
    push_request(REQ_LOAD, 0, 0, 24'h000000);
    push_request(REQ_RENDER, 0, 0, 24'hFFFFFF);
    push_request(REQ_RENDER, 255, 255, 0);
    push_request(REQ_RENDER, 256, 0, 0);
    push_request(REQ_RENDER, 4095, 4095, 0);
    push_request(REQ_RENDER, 0, 4095, 0);
    wait_idle();
    configure(192, 300, 1, 1, 280, 280, 200, 200);
    push_request(REQ_RENDER, 0, 0, 0);
    push_request(REQ_RENDER, 149, 149, 0);
    push_request(REQ_RENDER, 150, 0, 0);
    wait_idle();
    configure(64, 1024, 7, 2, 0, 0, 0, 0);
    push_request(REQ_RENDER, 0, 0, 0);
    push_request(REQ_RENDER, 1, 0, 0);
    wait_idle();
    configure(1, 65535, 6, 3, 4095, 4095, 1, 2);
    push_request(REQ_RENDER, 0, 0, 0);
    wait_idle();
    configure(65535, 1, 4, 1, 4095, 4095, 4096, 4096);
    push_request(REQ_RENDER, 0, 0, 0);
    push_request(REQ_RENDER, 255, 255, 0);
    wait_idle();

    // random phases over several register settings and sender gaps
    sender_gap_pct = 0;
    configure(256, 256, 0, 0, 0, 0, 12, 12);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 66;
    configure(192, 341, 1, 1, 0, 0, 12, 12);
    random_requests(55);
    pending_requests.push_back('{1'b1, REQ_LOAD, 12'd0, 12'd0, 24'd0});
    random_requests(55);
    wait_idle();

    sender_gap_pct = 6;
    configure(512, 128, 6, 1, 0, 0, 8, 8);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 0;
    configure(65535, 1, 7, 2, 4095, 4095, 4096, 4096);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 66;
    configure(64, 1024, 2, 2, 0, 0, 8, 12);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 6;
    configure(1, 65535, 5, 3, 0, 0, 1, 2);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 66;
    configure(100, 655, 3, 0, 244, 244, 4096, 4096);
    random_requests(110);
    wait_idle();

    sender_gap_pct = 0;
    configure(300, 200, 1, 0, 5, 5, 8, 8);
    random_requests(110);
    wait_idle();

    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
